>>> hw/rtl/rrrs_pkg.sv
// Shared types and constants for the rounded-rectangle row span block.
package rrrs_pkg;

  // Field widths
  localparam int DIM_W   = 12;              // width, height, radius, row
  localparam int START_W = 11;              // span start column
  localparam int RAD_W   = DIM_W - 1;       // clamped radius, at most half a side
  localparam int D_W     = 2 * DIM_W;       // radicand, below 4*r*r
  localparam int ROOT_W  = D_W / 2;         // square root of the radicand
  localparam int REM_W   = ROOT_W + 2;      // root remainder, at most 2*root
  localparam int SQ_STAGES = ROOT_W;        // one root digit per stage
  localparam int IDX_W   = 2;               // configuration index

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } cfg_reg_t;

  // Row classification that travels with the radicand
  typedef struct packed {
    logic             empty;   // no coverage at all
    logic             full;    // full width, no corner inset
    logic [DIM_W-1:0] two_r;   // twice the clamped radius
  } rrrs_info_t;

  typedef struct packed {
    rrrs_info_t     info;
    logic [D_W-1:0] d;
  } rrrs_sq_t;

  typedef struct packed {
    rrrs_info_t        info;
    logic [ROOT_W-1:0] root;
  } rrrs_root_t;

endpackage

>>> hw/rtl/rrrs_row_if.sv
// Row request channel: one row index per request.
interface rrrs_row_if;
  logic                        valid;
  logic                        ready;
  logic [rrrs_pkg::DIM_W-1:0]  row_index;

  modport source (output valid, output row_index, input ready);
  modport sink   (input valid, input row_index, output ready);
endinterface

>>> hw/rtl/rrrs_span_if.sv
// Span result channel: start column and length of one row.
interface rrrs_span_if;
  logic                          valid;
  logic                          ready;
  logic [rrrs_pkg::START_W-1:0]  span_start;
  logic [rrrs_pkg::DIM_W-1:0]    span_length;

  modport source (output valid, output span_start, output span_length, input ready);
  modport sink   (input valid, input span_start, input span_length, output ready);
endinterface

>>> hw/rtl/rrrs_front.sv
// Front stages: radius clamp, bottom mirror, row class, radicand multiply.
module rrrs_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rrrs_pkg::DIM_W-1:0]  width,
  input  logic [rrrs_pkg::DIM_W-1:0]  height,
  input  logic [rrrs_pkg::DIM_W-1:0]  radius,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rrrs_pkg::DIM_W-1:0]  row_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rrrs_pkg::rrrs_sq_t          out_data
);

  // Stage 1 registers
  logic                         v1;
  logic                         empty1;
  logic                         full1;
  logic [rrrs_pkg::RAD_W-1:0]   ym1;
  logic [rrrs_pkg::RAD_W-1:0]   r1;

  // Stage 2 register
  logic                         v2;

  logic ready1, ready2;

  // Stage 1 logic
  logic [rrrs_pkg::DIM_W-1:0]   min_side;
  logic [rrrs_pkg::RAD_W-1:0]   half;
  logic [rrrs_pkg::RAD_W-1:0]   r_clamp;
  logic [rrrs_pkg::DIM_W-1:0]   bottom_start;
  logic [rrrs_pkg::DIM_W-1:0]   y_mirror;
  logic                         empty_c;
  logic                         full_c;

  // Stage 2 logic
  logic [rrrs_pkg::DIM_W-1:0]   odd_y;      // 2y+1
  logic [rrrs_pkg::DIM_W:0]     far_term;   // 4r-2y-1
  logic [rrrs_pkg::D_W:0]       prod;

  assign ready2    = !v2 || out_ready;
  assign ready1    = !v1 || ready2;
  assign in_ready  = ready1;
  assign out_valid = v2;

  // Clamp radius, mirror the bottom corner band, classify the row
  always_comb begin
    min_side     = (width < height) ? width : height;
    half         = min_side[rrrs_pkg::DIM_W-1:1];
    r_clamp      = (radius > {1'b0, half}) ? half : radius[rrrs_pkg::RAD_W-1:0];
    bottom_start = height - {1'b0, r_clamp};
    y_mirror     = (row_index >= bottom_start) ? (height - 12'd1 - row_index) : row_index;
    empty_c      = (width == '0) || (height == '0) || (row_index >= height);
    full_c       = (r_clamp == '0) || (y_mirror >= {1'b0, r_clamp});
  end

  // D = (2y+1)(4r-2y-1) = 4r^2 - (2r-2y-1)^2
  always_comb begin
    odd_y    = {ym1, 1'b1};
    far_term = {r1, 2'b00} - {1'b0, ym1, 1'b0} - 13'd1;
    prod     = {13'b0, odd_y} * {12'b0, far_term};
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      empty1 <= empty_c;
      full1  <= full_c;
      ym1    <= y_mirror[rrrs_pkg::RAD_W-1:0];
      r1     <= r_clamp;
    end
    if (ready2 && v1) begin
      out_data.info.empty <= empty1;
      out_data.info.full  <= full1;
      out_data.info.two_r <= {r1, 1'b0};
      out_data.d          <= prod[rrrs_pkg::D_W-1:0];
    end
  end

endmodule

>>> hw/rtl/rrrs_sqrt.sv
// Pipelined integer square root, one root digit per stage.
module rrrs_sqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rrrs_pkg::rrrs_sq_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rrrs_pkg::rrrs_root_t out_data
);

  localparam int N = rrrs_pkg::SQ_STAGES;

  logic                          v     [N];
  logic                          rdy   [N+1];
  rrrs_pkg::rrrs_info_t          info  [N];
  logic [rrrs_pkg::D_W-1:0]      dsh   [N];
  logic [rrrs_pkg::REM_W-1:0]    rem   [N];
  logic [rrrs_pkg::ROOT_W-1:0]   root  [N];

  assign rdy[N]    = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v[N-1];
  assign out_data.info = info[N-1];
  assign out_data.root = root[N-1];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic                          vin;
    rrrs_pkg::rrrs_info_t          info_in;
    logic [rrrs_pkg::D_W-1:0]      d_in;
    logic [rrrs_pkg::REM_W-1:0]    rem_in;
    logic [rrrs_pkg::ROOT_W-1:0]   root_in;
    logic [rrrs_pkg::REM_W+1:0]    cur;
    logic [rrrs_pkg::REM_W+1:0]    trial;
    logic                          take;

    // Source of this stage: the input or the previous stage
    if (s == 0) begin : g_first
      assign vin     = in_valid;
      assign info_in = in_data.info;
      assign d_in    = in_data.d;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign vin     = v[s-1];
      assign info_in = info[s-1];
      assign d_in    = dsh[s-1];
      assign rem_in  = rem[s-1];
      assign root_in = root[s-1];
    end

    assign rdy[s] = !v[s] || rdy[s+1];

    // Bring down two radicand bits, try (4*root + 1)
    always_comb begin
      cur   = {rem_in, d_in[rrrs_pkg::D_W-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      take  = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (rdy[s]) begin
        v[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && vin) begin
        info[s] <= info_in;
        dsh[s]  <= {d_in[rrrs_pkg::D_W-3:0], 2'b00};
        rem[s]  <= take ? rrrs_pkg::REM_W'(cur - trial) : cur[rrrs_pkg::REM_W-1:0];
        root[s] <= {root_in[rrrs_pkg::ROOT_W-2:0], take};
      end
    end
  end

endmodule

>>> hw/rtl/rrrs_back.sv
// Output stage: corner inset from the root, span start and length register.
module rrrs_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rrrs_pkg::DIM_W-1:0]  width,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rrrs_pkg::rrrs_root_t        in_data,
  rrrs_span_if.source                 span
);

  logic                            ready;
  logic [rrrs_pkg::DIM_W:0]        ceil_sum;   // 2r - q + 1
  logic [rrrs_pkg::DIM_W-1:0]      inset;
  logic [rrrs_pkg::DIM_W:0]        both;       // 2*inset
  logic [rrrs_pkg::START_W-1:0]    start_c;
  logic [rrrs_pkg::DIM_W-1:0]      len_c;

  assign ready    = !span.valid || span.ready;
  assign in_ready = ready;

  // inset = ceil((2r - isqrt(D)) / 2), then span selection
  always_comb begin
    ceil_sum = {1'b0, in_data.info.two_r} - {1'b0, in_data.root} + 13'd1;
    inset    = ceil_sum[rrrs_pkg::DIM_W:1];
    both     = {inset, 1'b0};
    priority if (in_data.info.empty) begin
      start_c = '0;
      len_c   = '0;
    end else if (in_data.info.full) begin
      start_c = '0;
      len_c   = width;
    end else if (both >= {1'b0, width}) begin
      start_c = '0;
      len_c   = '0;
    end else begin
      start_c = inset[rrrs_pkg::START_W-1:0];
      len_c   = width - both[rrrs_pkg::DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span.valid <= 1'b0;
    end else if (ready) begin
      span.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      span.span_start  <= start_c;
      span.span_length <= len_c;
    end
  end

endmodule

>>> hw/rtl/rounded_rect_row_span.sv
// Top level of the rounded-rectangle row span generator.
//
//   channel  dir  payload                         handshake
//   row      in   row_index[11:0]                 valid/ready
//   span     out  span_start[10:0], span_length   valid/ready
//   cfg      in   cfg_index[1:0], cfg_data[11:0]  cfg_we, no back-pressure
//
// One request per cycle while the span output is not stalled; the path has
// two front stages (clamp and mirror, radicand multiply), twelve square-root
// stages of one digit each, and the output register. The root pipeline sets the depth.
// Reset clears the valid bits and the size and radius registers.
// Each stage has its own ready, so a stalled output holds only the stages
// behind it that are full; bubbles keep filling while a result waits.
module rounded_rect_row_span #(
  parameter int MAX_DIM = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rrrs_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rrrs_pkg::DIM_W-1:0]  cfg_data,
  rrrs_row_if.sink                    row,
  rrrs_span_if.source                 span
);

  localparam int FIELD_MAX = (1 << rrrs_pkg::DIM_W) - 1;
  localparam int SAT_INT   = (MAX_DIM - 1 > FIELD_MAX) ? FIELD_MAX : MAX_DIM - 1;
  localparam logic [rrrs_pkg::DIM_W-1:0] DIM_MAX = rrrs_pkg::DIM_W'(SAT_INT);

  logic [rrrs_pkg::DIM_W-1:0]  width;
  logic [rrrs_pkg::DIM_W-1:0]  height;
  logic [rrrs_pkg::DIM_W-1:0]  radius;
  logic [rrrs_pkg::DIM_W-1:0]  cfg_sat;

  logic                 f_valid, f_ready;
  rrrs_pkg::rrrs_sq_t   f_data;
  logic                 s_valid, s_ready;
  rrrs_pkg::rrrs_root_t s_data;

  // Size registers, saturated to the largest supported dimension
  assign cfg_sat = (cfg_data > DIM_MAX) ? DIM_MAX : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= '0;
      height <= '0;
      radius <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrrs_pkg::REG_WIDTH:  width  <= cfg_sat;
        rrrs_pkg::REG_HEIGHT: height <= cfg_sat;
        rrrs_pkg::REG_RADIUS: radius <= cfg_sat;
        default: ;
      endcase
    end
  end

  rrrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .width     (width),
    .height    (height),
    .radius    (radius),
    .in_valid  (row.valid),
    .in_ready  (row.ready),
    .row_index (row.row_index),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  rrrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_data  (s_data)
  );

  rrrs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .width    (width),
    .in_valid (s_valid),
    .in_ready (s_ready),
    .in_data  (s_data),
    .span     (span)
  );

endmodule
